// ===== design/bil_pkg.sv =====
// shared constants, codes and types of the bilinear rgba sampler
package bil_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int FRAC_BITS   = 8;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SIZE_W      = 9;
    localparam int COORD_W     = 18;
    localparam int PIX_W       = 32;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = PIX_W / CH_W;

    localparam int NUM_BANKS   = 4;
    localparam int BANK_AW     = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH  = 1 << BANK_AW;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // decoded request handed from the front end to the back end
    typedef struct packed {
        logic                 is_sample;
        logic                 empty;
        logic [COL_W-1:0]     col0;
        logic [COL_W-1:0]     col1;
        logic [ROW_W-1:0]     row0;
        logic [ROW_W-1:0]     row1;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [PIX_W-1:0]     word;
    } cmd_t;

endpackage

// ===== design/bil_if.sv =====
// channel interfaces of the bilinear rgba sampler

interface bil_req_if import bil_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [COL_W-1:0]          pixel_column;
    logic [ROW_W-1:0]          pixel_row;
    logic [PIX_W-1:0]          pixel_word;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;

    modport source (output valid, opcode, pixel_column, pixel_row, pixel_word,
                    sample_x, sample_y, input ready);
    modport sink   (input valid, opcode, pixel_column, pixel_row, pixel_word,
                    sample_x, sample_y, output ready);
endinterface

interface bil_rsp_if import bil_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            sample_valid;

    modport source (output valid, red, green, blue, alpha, sample_valid, input ready);
    modport sink   (input valid, red, green, blue, alpha, sample_valid, output ready);
endinterface

interface bil_cfg_if import bil_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/bil_front.sv =====
// front end: configuration registers, request decode and coordinate clamp
module bil_front import bil_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bil_cfg_if.sink   cfg,
    bil_req_if.sink   req,
    input  logic      q_full,
    output logic      push,
    output cmd_t      cmd
);

    logic [SIZE_W-1:0]          image_width_reg;
    logic [SIZE_W-1:0]          image_height_reg;
    logic [SIZE_W-1:0]          eff_w;
    logic [SIZE_W-1:0]          eff_h;
    logic [COL_W-1:0]           x_last;
    logic [ROW_W-1:0]           y_last;
    logic [COL_W+FRAC_BITS-1:0] x_top;
    logic [ROW_W+FRAC_BITS-1:0] y_top;
    logic [COL_W+FRAC_BITS-1:0] cx;
    logic [ROW_W+FRAC_BITS-1:0] cy;
    logic [COL_W-1:0]           x0;
    logic [COL_W-1:0]           x1;
    logic [ROW_W-1:0]           y0;
    logic [ROW_W-1:0]           y1;
    logic                       is_sample;

    assign cfg.ready = 1'b1;
    assign req.ready = !q_full;
    assign push      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        // sizes above the store saturate
        eff_w = (image_width_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : image_width_reg;
        eff_h = (image_height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT)
                                                           : image_height_reg;
        x_last = COL_W'(eff_w - SIZE_W'(1));
        y_last = ROW_W'(eff_h - SIZE_W'(1));
        x_top  = {x_last, {FRAC_BITS{1'b0}}};
        y_top  = {y_last, {FRAC_BITS{1'b0}}};

        if (req.sample_x[COORD_W-1])
            cx = '0;
        else if (req.sample_x > $signed({1'b0, x_top}))
            cx = x_top;
        else
            cx = req.sample_x[COL_W+FRAC_BITS-1:0];

        if (req.sample_y[COORD_W-1])
            cy = '0;
        else if (req.sample_y > $signed({1'b0, y_top}))
            cy = y_top;
        else
            cy = req.sample_y[ROW_W+FRAC_BITS-1:0];

        x0 = cx[COL_W+FRAC_BITS-1:FRAC_BITS];
        y0 = cy[ROW_W+FRAC_BITS-1:FRAC_BITS];
        x1 = (SIZE_W'(x0) + SIZE_W'(1) < eff_w) ? x0 + COL_W'(1) : x_last;
        y1 = (SIZE_W'(y0) + SIZE_W'(1) < eff_h) ? y0 + ROW_W'(1) : y_last;

        is_sample = (req.opcode == OP_SAMPLE);

        cmd.is_sample = is_sample;
        cmd.empty     = (eff_w == '0) || (eff_h == '0);
        cmd.col0      = is_sample ? x0 : req.pixel_column;
        cmd.col1      = x1;
        cmd.row0      = is_sample ? y0 : req.pixel_row;
        cmd.row1      = y1;
        cmd.fx        = cx[FRAC_BITS-1:0];
        cmd.fy        = cy[FRAC_BITS-1:0];
        cmd.word      = req.pixel_word;
    end

endmodule

// ===== design/bil_queue.sv =====
// short request queue between front end and back end
module bil_queue import bil_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic full,
    output logic not_empty,
    input  logic pop,
    output cmd_t rd_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + (QPTR_W + 1)'(1)))
        else $error("queue count did not grow on a lone push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

endmodule

// ===== design/bil_back.sv =====
// back end: parity-banked image store, horizontal and vertical blend lanes
module bil_back import bil_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    bil_rsp_if.source rsp
);

    localparam int HL_W = CH_W + FRAC_BITS + 2;
    localparam int VL_W = CH_W + 2 * FRAC_BITS + 2;
    localparam int LV_W = CH_W + FRAC_BITS;

    logic [PIX_W-1:0]   bank_mem [NUM_BANKS][BANK_DEPTH];
    logic [PIX_W-1:0]   bank_q_reg [NUM_BANKS];
    logic [BANK_AW-1:0] bank_addr [NUM_BANKS];
    logic               bank_we [NUM_BANKS];
    logic               bank_re [NUM_BANKS];

    logic               advance;

    // memory stage
    logic                 m_valid_reg;
    logic                 m_empty_reg;
    logic [FRAC_BITS-1:0] m_fx_reg;
    logic [FRAC_BITS-1:0] m_fy_reg;
    logic                 m_x0p_reg;
    logic                 m_x1p_reg;
    logic                 m_y0p_reg;
    logic                 m_y1p_reg;
    logic [PIX_W-1:0]     p00;
    logic [PIX_W-1:0]     p10;
    logic [PIX_W-1:0]     p01;
    logic [PIX_W-1:0]     p11;

    // horizontal stage
    logic                 h_valid_reg;
    logic                 h_empty_reg;
    logic [FRAC_BITS-1:0] h_fy_reg;
    logic [LV_W-1:0]      h_top_reg [NUM_CH];
    logic [LV_W-1:0]      h_bot_reg [NUM_CH];
    logic [LV_W-1:0]      h_top_next [NUM_CH];
    logic [LV_W-1:0]      h_bot_next [NUM_CH];

    // vertical stage, also the output register
    logic                 v_valid_reg;
    logic                 v_ok_reg;
    logic [CH_W-1:0]      v_ch_reg [NUM_CH];
    logic [CH_W-1:0]      v_ch_next [NUM_CH];

    function automatic logic [PIX_W-1:0] pick(input logic yp, input logic xp,
                                              input logic [PIX_W-1:0] q0,
                                              input logic [PIX_W-1:0] q1,
                                              input logic [PIX_W-1:0] q2,
                                              input logic [PIX_W-1:0] q3);
        logic [PIX_W-1:0] r;
        r = yp ? (xp ? q3 : q2) : (xp ? q1 : q0);
        return r;
    endfunction

    function automatic logic [LV_W-1:0] lerp_h(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [FRAC_BITS-1:0] f);
        logic signed [CH_W:0]      d;
        logic signed [FRAC_BITS:0] fs;
        logic signed [HL_W-1:0]    base;
        logic signed [HL_W-1:0]    prod;
        logic signed [HL_W-1:0]    s;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        fs   = $signed({1'b0, f});
        base = $signed({2'b00, a, {FRAC_BITS{1'b0}}});
        prod = HL_W'(d) * HL_W'(fs);
        s    = base + prod;
        return s[LV_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] lerp_v(input logic [LV_W-1:0] a,
                                               input logic [LV_W-1:0] b,
                                               input logic [FRAC_BITS-1:0] f);
        logic signed [LV_W:0]      d;
        logic signed [FRAC_BITS:0] fs;
        logic signed [VL_W-1:0]    base;
        logic signed [VL_W-1:0]    prod;
        logic signed [VL_W-1:0]    s;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        fs   = $signed({1'b0, f});
        base = $signed({2'b00, a, {FRAC_BITS{1'b0}}});
        prod = VL_W'(d) * VL_W'(fs);
        // round half up; the blend never exceeds the channel maximum
        s    = base + prod + VL_W'(1 << (2 * FRAC_BITS - 1));
        return s[CH_W+2*FRAC_BITS-1:2*FRAC_BITS];
    endfunction

    // the whole back end moves when the output register is free or taken
    assign advance = !v_valid_reg || rsp.ready;
    assign q_pop   = q_valid && advance;

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic CP = 1'(b % 2);
        localparam logic RP = 1'(b / 2);
        logic [COL_W-1:0] col_sel;
        logic [ROW_W-1:0] row_sel;

        assign col_sel      = (q_cmd.col0[0] == CP) ? q_cmd.col0 : q_cmd.col1;
        assign row_sel      = (q_cmd.row0[0] == RP) ? q_cmd.row0 : q_cmd.row1;
        assign bank_addr[b] = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};
        assign bank_we[b]   = q_pop && !q_cmd.is_sample
                              && (q_cmd.col0[0] == CP) && (q_cmd.row0[0] == RP);
        assign bank_re[b]   = q_pop && q_cmd.is_sample && !q_cmd.empty;

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                bank_mem[b][bank_addr[b]] <= q_cmd.word;
            if (bank_re[b])
                bank_q_reg[b] <= bank_mem[b][bank_addr[b]];
        end
    end

    always_comb
    begin
        p00 = pick(m_y0p_reg, m_x0p_reg, bank_q_reg[0], bank_q_reg[1],
                   bank_q_reg[2], bank_q_reg[3]);
        p10 = pick(m_y0p_reg, m_x1p_reg, bank_q_reg[0], bank_q_reg[1],
                   bank_q_reg[2], bank_q_reg[3]);
        p01 = pick(m_y1p_reg, m_x0p_reg, bank_q_reg[0], bank_q_reg[1],
                   bank_q_reg[2], bank_q_reg[3]);
        p11 = pick(m_y1p_reg, m_x1p_reg, bank_q_reg[0], bank_q_reg[1],
                   bank_q_reg[2], bank_q_reg[3]);
        for (int c = 0; c < NUM_CH; c++)
        begin
            h_top_next[c] = lerp_h(p00[PIX_W-1-CH_W*c -: CH_W],
                                   p10[PIX_W-1-CH_W*c -: CH_W], m_fx_reg);
            h_bot_next[c] = lerp_h(p01[PIX_W-1-CH_W*c -: CH_W],
                                   p11[PIX_W-1-CH_W*c -: CH_W], m_fx_reg);
            v_ch_next[c]  = h_empty_reg ? '0
                                        : lerp_v(h_top_reg[c], h_bot_reg[c], h_fy_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            v_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= q_pop && q_cmd.is_sample;
            h_valid_reg <= m_valid_reg;
            v_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_empty_reg <= q_cmd.empty;
            m_fx_reg    <= q_cmd.fx;
            m_fy_reg    <= q_cmd.fy;
            m_x0p_reg   <= q_cmd.col0[0];
            m_x1p_reg   <= q_cmd.col1[0];
            m_y0p_reg   <= q_cmd.row0[0];
            m_y1p_reg   <= q_cmd.row1[0];
            h_empty_reg <= m_empty_reg;
            h_fy_reg    <= m_fy_reg;
            h_top_reg   <= h_top_next;
            h_bot_reg   <= h_bot_next;
            v_ok_reg    <= !h_empty_reg;
            v_ch_reg    <= v_ch_next;
        end
    end

    assign rsp.valid        = v_valid_reg;
    assign rsp.red          = v_ch_reg[0];
    assign rsp.green        = v_ch_reg[1];
    assign rsp.blue         = v_ch_reg[2];
    assign rsp.alpha        = v_ch_reg[3];
    assign rsp.sample_valid = v_ok_reg;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.sample_valid) |->
        (rsp.red == '0 && rsp.green == '0 && rsp.blue == '0 && rsp.alpha == '0))
        else $error("empty image gave nonzero channels");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (h_valid_reg && !advance) |=> h_valid_reg)
        else $error("sample lost in blend stage during stall");

endmodule

// ===== design/bilinear_rgba_sampler_unit.sv =====
// top level of the bilinear rgba sampler with clamp-to-edge addressing
//
//  channel | dir | fields                                              | role
//  --------+-----+-----------------------------------------------------+------------------
//  cfg     | in  | index, data                                         | register writes
//  req     | in  | opcode, pixel_column, pixel_row, pixel_word, x, y   | pixel write/sample
//  rsp     | out | red, green, blue, alpha, sample_valid               | one per sample
//
// one request per cycle sustained, pixel writes and samples alike, while the queue is not full
// a sample's response comes through the queue, then pop with store read, horizontal blend and
// vertical blend into the output register
// four neighbours come from one read of each of four row/column parity banks
// reset clears control only; the image store holds nothing until written
// a stalled response holds the back end; the front keeps taking requests until the
// four-entry queue fills
module bilinear_rgba_sampler_unit import bil_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bil_cfg_if.sink   cfg,
    bil_req_if.sink   req,
    bil_rsp_if.source rsp
);

    // front end to queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue to back end
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // decode and clamp each request, hold the image size
    bil_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    // decouples request acceptance from response stalls
    bil_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (push_cmd),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .rd_cmd    (q_cmd)
    );

    // store writes, neighbour reads and the blend pipeline
    bil_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

// ===== tb/sv/bilinear_rgba_sampler_checker.sv =====
// scoreboard that predicts and checks every sample of the bilinear rgba sampler
`timescale 1ns / 100ps
module bilinear_rgba_sampler_checker import bil_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bil_cfg_if   cfg,
    bil_req_if   req,
    bil_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   texels_checked,
    output int   empty_checked
);

    localparam int ONE_FX   = 1 << FRAC_BITS;
    localparam int HALF_LSB = 1 << (2 * FRAC_BITS - 1);
    localparam int CH_MAX   = (1 << CH_W) - 1;

    // field order matches the packed blend result with sample_valid below it
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            sample_valid;
    } texel_t;

    logic [PIX_W-1:0]  pixel_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    texel_t            expected_texels [$];
    texel_t            oldest;

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        texels_checked = 0;
        empty_checked  = 0;
    end

    // clamp to [0, size-1] in fixed point, split into cell, edge-clamped neighbour, fraction
    function automatic void clamp_axis(input int coord, input int size,
                                       output int c0, output int c1, output int frac);
        int top_fx;
        top_fx = (size - 1) * ONE_FX;
        if (coord < 0)
            coord = 0;
        if (coord > top_fx)
            coord = top_fx;
        c0   = coord >> FRAC_BITS;
        frac = coord & (ONE_FX - 1);
        c1   = (c0 + 1 < size) ? c0 + 1 : size - 1;
    endfunction

    function automatic logic [CH_W-1:0] blend_channel(int q00, int q10, int q01, int q11,
                                                      int fx, int fy);
        int upper;
        int lower;
        int acc;
        upper = q00 * (ONE_FX - fx) + q10 * fx;
        lower = q01 * (ONE_FX - fx) + q11 * fx;
        acc   = (upper * (ONE_FX - fy) + lower * fy + HALF_LSB) >> (2 * FRAC_BITS);
        return CH_W'((acc > CH_MAX) ? CH_MAX : acc);
    endfunction

    function automatic int channel_of(logic [PIX_W-1:0] word, int k);
        return int'(word[(NUM_CH - 1 - k) * CH_W +: CH_W]);
    endfunction

    function automatic texel_t predict_texel(logic signed [COORD_W-1:0] sx,
                                             logic signed [COORD_W-1:0] sy);
        int               w;
        int               h;
        int               x0;
        int               x1;
        int               y0;
        int               y1;
        int               fx;
        int               fy;
        int               k;
        logic [PIX_W-1:0] q00;
        logic [PIX_W-1:0] q10;
        logic [PIX_W-1:0] q01;
        logic [PIX_W-1:0] q11;
        logic [PIX_W-1:0] mix;
        w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        if (w == 0 || h == 0)
            return '0;
        clamp_axis(int'(sx), w, x0, x1, fx);
        clamp_axis(int'(sy), h, y0, y1, fy);
        q00 = pixel_mem[y0 * MAX_WIDTH + x0];
        q10 = pixel_mem[y0 * MAX_WIDTH + x1];
        q01 = pixel_mem[y1 * MAX_WIDTH + x0];
        q11 = pixel_mem[y1 * MAX_WIDTH + x1];
        for (k = 0; k < NUM_CH; k++)
            mix[(NUM_CH - 1 - k) * CH_W +: CH_W] =
                blend_channel(channel_of(q00, k), channel_of(q10, k),
                              channel_of(q01, k), channel_of(q11, k), fx, fy);
        return {mix, 1'b1};
    endfunction

    task automatic check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = '0;
            height_reg = '0;
            expected_texels.delete();
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_IMAGE_WIDTH)
                    width_reg = cfg.data;
                else if (cfg.index == REG_IMAGE_HEIGHT)
                    height_reg = cfg.data;
            end

            if (rsp.valid && rsp.ready)
            begin
                if (expected_texels.size() == 0)
                begin
                    $error("response with no sample outstanding: rgba %0h %0h %0h %0h valid %0b",
                           rsp.red, rsp.green, rsp.blue, rsp.alpha, rsp.sample_valid);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_texels.pop_front();
                    check_field("red", oldest.red, rsp.red);
                    check_field("green", oldest.green, rsp.green);
                    check_field("blue", oldest.blue, rsp.blue);
                    check_field("alpha", oldest.alpha, rsp.alpha);
                    check_field("sample_valid", CH_W'(oldest.sample_valid),
                                CH_W'(rsp.sample_valid));
                    texels_checked++;
                    if (!oldest.sample_valid)
                        empty_checked++;
                end
            end

            if (req.valid && req.ready)
            begin
                if (op_t'(req.opcode) == OP_WRITE)
                    pixel_mem[int'(req.pixel_row) * MAX_WIDTH + int'(req.pixel_column)] =
                        req.pixel_word;
                else
                    expected_texels.push_back(predict_texel(req.sample_x, req.sample_y));
            end

            pending = expected_texels.size();
        end
    end

endmodule

// ===== tb/sv/bilinear_rgba_sampler_unit_tb.sv =====
// testbench top of the bilinear rgba sampler: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps
module bilinear_rgba_sampler_unit_tb import bil_pkg::*; ();

    localparam int ITEM_TARGET   = 850;
    localparam int PHASE_SAMPLES = 40;
    localparam int WINDOW_MAX    = 6;
    // a write gives nothing back, so this covers a write still in flight when the last
    // result came out
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    // far above the length of the slowest legal run
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ONE_FX        = 1 << FRAC_BITS;
    localparam int COORD_MAX     = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN     = -(1 << (COORD_W - 1));
    localparam int IDX_SPARE_LO  = int'(REG_IMAGE_HEIGHT) + 1;
    localparam int IDX_SPARE_HI  = (1 << CFG_IDX_W) - 1;

    logic clk;
    logic rst_n;

    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_request       = 1'b0;

    int n_sent     = 0;
    int n_writes   = 0;
    int n_samples  = 0;
    int n_settings = 0;

    int fail_count;
    int pending;
    int texels_checked;
    int empty_checked;

    bil_cfg_if cfg_ch ();
    bil_req_if req_ch ();
    bil_rsp_if rsp_ch ();

    bilinear_rgba_sampler_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bilinear_rgba_sampler_checker sampler_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .texels_checked (texels_checked),
        .empty_checked  (empty_checked)
    );

    initial
        clk = 1'b0;
    always #2 clk = ~clk;

    // watchdog: a hung handshake or a lost sample ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // response side: random stalls per phase, plus one long hold-off on request so
    // the internal queue fills and the block has to push back on its input
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // one request; valid goes up at a falling edge and stays until a rising edge sees ready
    task automatic push_request(op_t op, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                logic [PIX_W-1:0] word, logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.opcode       = op;
        req_ch.pixel_column = col;
        req_ch.pixel_row    = row;
        req_ch.pixel_word   = word;
        req_ch.sample_x     = x;
        req_ch.sample_y     = y;
        do
            @(posedge clk);
        while (!req_ch.ready);
        n_sent++;
        if (op == OP_WRITE)
            n_writes++;
        else
            n_samples++;
    endtask

    // sample with random junk in the pixel fields, which a sample ignores
    task automatic sample_at(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        push_request(OP_SAMPLE, COL_W'($urandom), ROW_W'($urandom), $urandom, x, y);
    endtask

    // write anywhere in the store, inside the image or not; coordinates are junk
    task automatic scatter_write();
        push_request(OP_WRITE, COL_W'($urandom), ROW_W'($urandom), $urandom,
                     COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // stop offering, let every outstanding sample come back, then let writes settle
    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            n_settings++;
    endtask

    // coordinate on one axis whose cell and clamped neighbour both fall in the written
    // window [lo, lo+span-1]; off-image values only where the window touches that edge
    function automatic logic signed [COORD_W-1:0] pick_axis(int lo, int span, int size);
        int last_pos;
        int roll;
        int v;
        last_pos = (lo + span == size) ? size - 1 : lo + span - 2;
        roll     = $urandom_range(9);
        if (lo == 0 && roll == 0)
            v = -int'($urandom_range(-COORD_MIN, 1));
        else if (lo + span == size && roll == 1)
            v = int'($urandom_range(COORD_MAX, (size - 1) << FRAC_BITS));
        else
            v = (int'($urandom_range(last_pos, lo)) << FRAC_BITS) |
                int'($urandom_range(ONE_FX - 1));
        return COORD_W'(v);
    endfunction

    // window origin: hug the low edge, hug the high edge, or anywhere
    function automatic int pick_origin(int size, int span);
        int roll;
        roll = $urandom_range(2);
        if (roll == 0)
            return 0;
        else if (roll == 1)
            return size - span;
        return $urandom_range(size - span, 0);
    endfunction

    // hand-picked cases on a tiny 3x2 image and on empty images
    task automatic directed_checks();
        // registers come out of reset at zero: no image yet
        sample_at(COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
        sample_at(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
        drain();
        write_register(REG_IMAGE_WIDTH, 9'd3);
        write_register(REG_IMAGE_HEIGHT, 9'd2);
        push_request(OP_WRITE, 8'd0, 8'd0, 32'h0000_0000, COORD_W'(COORD_MAX), '0);
        push_request(OP_WRITE, 8'd1, 8'd0, 32'h0101_0101, COORD_W'(COORD_MIN), '1);
        push_request(OP_WRITE, 8'd2, 8'd0, 32'hFFFF_FFFF, '0, '0);
        push_request(OP_WRITE, 8'd0, 8'd1, 32'h80FF_4020, '1, '1);
        push_request(OP_WRITE, 8'd1, 8'd1, 32'h7F00_C0DF, '0, '1);
        push_request(OP_WRITE, 8'd2, 8'd1, 32'hA5A5_5A5A, '1, '0);
        // store corner, far outside the current image but still kept
        push_request(OP_WRITE, 8'hFF, 8'hFF, 32'h5A5A_A5A5, '0, '0);
        // half way between 0 and 1 rounds up to 1
        sample_at(18'sh00080, 18'sh00000);
        sample_at(18'sh00000, 18'sh00000);
        // far negative clamps to the first cell, far positive to the last
        sample_at(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
        sample_at(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
        // just past the last column and row: clamped with zero fraction
        sample_at(18'sh002FF, 18'sh001FF);
        sample_at(18'sh001C0, 18'sh000FF);
        sample_at(18'sh000FF, 18'sh00080);
        // last column: right neighbour folds back onto the same column
        sample_at(18'sh00200, 18'sh00040);
        drain();
        // unused register index must leave the size alone
        write_register(CFG_IDX_W'(IDX_SPARE_HI), 9'd0);
        write_register(REG_IMAGE_WIDTH, 9'd0);
        sample_at(18'sh00100, 18'sh00080);
        drain();
        write_register(REG_IMAGE_WIDTH, 9'd2);
        write_register(REG_IMAGE_HEIGHT, 9'd0);
        sample_at(18'sh00080, 18'sh00080);
    endtask

    // one size setting: fill a small window of the image, then sample inside it with
    // some scattered writes mixed in; empty images get wild coordinates instead
    task automatic run_phase(logic [SIZE_W-1:0] w_reg, logic [SIZE_W-1:0] h_reg, int mode,
                             bit do_hold);
        int eff_w;
        int eff_h;
        int ox;
        int oy;
        int wx;
        int wy;
        int r;
        int c;
        drain();
        write_register(REG_IMAGE_WIDTH, w_reg);
        write_register(REG_IMAGE_HEIGHT, h_reg);
        if ($urandom_range(3) == 0)
            write_register(CFG_IDX_W'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)),
                           SIZE_W'($urandom));
        // sizes above the store saturate in the block
        eff_w = (w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(w_reg);
        eff_h = (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_reg);

        // pacing: free flow, idle sender, stalling receiver, then a bit of both
        case (mode % 4)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 49;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 49;
            end
            default:
            begin
                sender_idle_pct    = 14;
                receiver_stall_pct = 14;
            end
        endcase

        if (eff_w == 0 || eff_h == 0)
        begin
            repeat (PHASE_SAMPLES)
            begin
                if ($urandom_range(4) == 0)
                    scatter_write();
                else
                    sample_at(COORD_W'($urandom), COORD_W'($urandom));
            end
        end
        else
        begin
            wx = (eff_w == 1) ? 1 :
                 $urandom_range((eff_w < WINDOW_MAX) ? eff_w : WINDOW_MAX, 2);
            wy = (eff_h == 1) ? 1 :
                 $urandom_range((eff_h < WINDOW_MAX) ? eff_h : WINDOW_MAX, 2);
            ox = pick_origin(eff_w, wx);
            oy = pick_origin(eff_h, wy);
            for (r = oy; r < oy + wy; r++)
                for (c = ox; c < ox + wx; c++)
                    push_request(OP_WRITE, COL_W'(c), ROW_W'(r), $urandom,
                                 COORD_W'($urandom), COORD_W'($urandom));
            if (do_hold)
                hold_request = 1'b1;
            repeat (PHASE_SAMPLES)
            begin
                if ($urandom_range(5) == 0)
                    scatter_write();
                else
                    sample_at(pick_axis(ox, wx, eff_w), pick_axis(oy, wy, eff_h));
            end
        end
    endtask

    initial
    begin
        int                phase;
        logic [SIZE_W-1:0] w_reg;
        logic [SIZE_W-1:0] h_reg;

        // every input known from time zero
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_WRITE;
        req_ch.pixel_column = '0;
        req_ch.pixel_row    = '0;
        req_ch.pixel_word   = '0;
        req_ch.sample_x     = '0;
        req_ch.sample_y     = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        directed_checks();

        // size settings: the corners first, then mostly small random images with the
        // occasional full 9-bit register value
        phase = 0;
        while (n_sent < ITEM_TARGET)
        begin
            case (phase)
                0:
                begin
                    w_reg = 9'd1;
                    h_reg = 9'd1;
                end
                1:
                begin
                    w_reg = 9'd256;
                    h_reg = 9'd256;
                end
                2:
                begin
                    w_reg = 9'd511;
                    h_reg = 9'd300;
                end
                3:
                begin
                    w_reg = 9'd0;
                    h_reg = 9'd17;
                end
                4:
                begin
                    w_reg = 9'd2;
                    h_reg = 9'd2;
                end
                5:
                begin
                    w_reg = 9'd256;
                    h_reg = 9'd1;
                end
                6:
                begin
                    w_reg = 9'd1;
                    h_reg = 9'd256;
                end
                7:
                begin
                    w_reg = 9'd40;
                    h_reg = 9'd0;
                end
                default:
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        w_reg = SIZE_W'($urandom);
                        h_reg = SIZE_W'($urandom);
                    end
                    else
                    begin
                        w_reg = SIZE_W'($urandom_range(24, 1));
                        h_reg = SIZE_W'($urandom_range(24, 1));
                    end
                end
            endcase
            // the long output hold-off lands on the free-flowing 2x2 phase
            run_phase(w_reg, h_reg, phase, phase == 4);
            phase++;
        end

        drain();

        $display("covered %0d requests: %0d pixel writes and %0d samples over %0d sizes",
                 n_sent, n_writes, n_samples, n_settings);
        $display("compared %0d results, %0d on an empty image, with one long output stall",
                 texels_checked, empty_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
